FILE: rtl/ebs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ebs_pkg;

    // Fixed field widths of the ports
    localparam int POINT_W = 63;
    localparam int PCT_W   = 7;
    localparam int FRAME_W = 16;
    localparam int EASED_W = 17;

    // Default geometry of the sampler
    localparam int MAX_SAMPLES_DEF    = 64;
    localparam int OVERSAMPLE_DEF     = 10;
    localparam int COORD_BITS_DEF     = 21;
    localparam int TIME_FRAC_BITS_DEF = 16;

    // Arithmetic constants of the easing curve
    localparam int PCT_FULL     = 100;
    localparam int EASE_TANGENT = 3;

    // Controller wait lengths
    localparam logic [2:0] TB_LAT  = 3'd6;
    localparam logic [2:0] BEZ_LAT = 3'd3;

    // Divider operand selection
    localparam logic [1:0] DIV_X = 2'd0;
    localparam logic [1:0] DIV_Y = 2'd1;
    localparam logic [1:0] DIV_T = 2'd2;
    localparam logic [1:0] DIV_S = 2'd3;

    // Eased time source
    localparam logic [1:0] S_LO = 2'd0;
    localparam logic [1:0] S_HI = 2'd1;
    localparam logic [1:0] S_Q  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       k_inc;
        logic       div_start;
        logic [1:0] div_sel;
        logic       wr_x;
        logic       wr_y;
        logic       i_inc;
        logic       t_take;
        logic       scan_clr;
        logic       scan_inc;
        logic       rd_en;
        logic       lo_take;
        logic       s_load;
        logic [1:0] s_sel;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic k_last;
        logic i_last;
        logic hi_end;
        logic x_gt;
        logic degen;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/ebs_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ebs_div #(
    parameter int DIV_W = 40,
    parameter int QB    = 17
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIV_W+QB-1:0]   i_dividend,
    input  wire logic [DIV_W-1:0]      i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [QB-1:0]              o_quot
);
    localparam int CNT_W = $clog2(QB + 1);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_d;
    logic [QB-1:0]    r_low;
    logic [QB-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   shifted;
    logic             qbit;

    // one quotient bit a cycle, restoring
    always_comb begin
        shifted = {r_rem, r_low[QB-1]};
        qbit    = (shifted >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DIV_W+QB-1:QB];
            r_low <= i_dividend[QB-1:0];
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? DIV_W'(shifted - {1'b0, r_d}) : shifted[DIV_W-1:0];
            r_low <= {r_low[QB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

FILE: rtl/ebs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ebs_ctrl
    import ebs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TB     = 4'd1;
    localparam logic [3:0] ST_DIVX   = 4'd2;
    localparam logic [3:0] ST_WX     = 4'd3;
    localparam logic [3:0] ST_WY     = 4'd4;
    localparam logic [3:0] ST_SMPT   = 4'd5;
    localparam logic [3:0] ST_WT     = 4'd6;
    localparam logic [3:0] ST_RD0    = 4'd7;
    localparam logic [3:0] ST_LO0    = 4'd8;
    localparam logic [3:0] ST_RDH    = 4'd9;
    localparam logic [3:0] ST_CHK    = 4'd10;
    localparam logic [3:0] ST_INTERP = 4'd11;
    localparam logic [3:0] ST_DIVS   = 4'd12;
    localparam logic [3:0] ST_WS     = 4'd13;
    localparam logic [3:0] ST_BEZ    = 4'd14;
    localparam logic [3:0] ST_PUSH   = 4'd15;

    logic [3:0] r_state, n_state;
    logic [2:0] r_wait, n_wait;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_wait  = r_wait;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_TB;
                end
            end
            ST_TB: begin
                if (r_wait == 3'd0) begin
                    n_state = ST_DIVX;
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            ST_DIVX: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_X;
                n_state         = ST_WX;
            end
            ST_WX: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_x      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_Y;
                    n_state         = ST_WY;
                end
            end
            ST_WY: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_y = 1'b1;
                    if (i_sts.k_last) begin
                        n_state = ST_SMPT;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = ST_TB;
                    end
                end
            end
            ST_SMPT: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_T;
                n_state         = ST_WT;
            end
            ST_WT: begin
                if (i_sts.div_done) begin
                    o_cmd.t_take   = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_RD0;
                end
            end
            ST_RD0: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_LO0;
            end
            ST_LO0: begin
                o_cmd.lo_take  = 1'b1;
                o_cmd.scan_inc = 1'b1;
                n_state        = ST_RDH;
            end
            ST_RDH: begin
                if (i_sts.hi_end) begin
                    o_cmd.s_load = 1'b1;
                    o_cmd.s_sel  = S_LO;
                    n_state      = ST_BEZ;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_sts.x_gt) begin
                    n_state = ST_INTERP;
                end else begin
                    o_cmd.lo_take  = 1'b1;
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_RDH;
                end
            end
            ST_INTERP: begin
                if (i_sts.degen) begin
                    o_cmd.s_load = 1'b1;
                    o_cmd.s_sel  = S_HI;
                    n_state      = ST_BEZ;
                end else begin
                    n_state = ST_DIVS;
                end
            end
            ST_DIVS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_S;
                n_state         = ST_WS;
            end
            ST_WS: begin
                if (i_sts.div_done) begin
                    o_cmd.s_load = 1'b1;
                    o_cmd.s_sel  = S_Q;
                    n_state      = ST_BEZ;
                end
            end
            ST_BEZ: begin
                if (r_wait == 3'd0) begin
                    n_state = ST_PUSH;
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.i_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state     = ST_SMPT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // arm the wait counter on entry
        if (n_state != r_state) begin
            n_wait = (n_state == ST_TB) ? TB_LAT - 3'd1 : BEZ_LAT - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule
`default_nettype wire

FILE: rtl/ebs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ebs_dp
    import ebs_pkg::*;
#(
    parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
    parameter int OVERSAMPLE     = OVERSAMPLE_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [POINT_W-1:0] i_knot_start,
    input  wire logic [POINT_W-1:0] i_handle_out,
    input  wire logic [POINT_W-1:0] i_handle_in,
    input  wire logic [POINT_W-1:0] i_knot_end,
    input  wire logic [PCT_W-1:0]   i_ease_out_pct,
    input  wire logic [PCT_W-1:0]   i_ease_in_pct,
    input  wire logic [FRAME_W-1:0] i_frame_first,
    input  wire logic [FRAME_W-1:0] i_frame_last,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [POINT_W-1:0]      o_position,
    output logic [FRAME_W-1:0]      o_frame,
    output logic [EASED_W-1:0]      o_eased_time,
    output logic                    o_clamped,
    output logic                    o_last_sample
);
    localparam int DEPTH = MAX_SAMPLES * OVERSAMPLE;
    localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int M_W   = $clog2(DEPTH + 1);
    localparam int N_W   = $clog2(MAX_SAMPLES + 1);
    localparam int C     = COORD_BITS;
    localparam int F     = TIME_FRAC_BITS;
    localparam int T_W   = F + 1;
    localparam int DEN_W = 3 * M_W + 7;
    localparam int DIV_W = (DEN_W > T_W) ? DEN_W : T_W + 1;
    localparam int NUM_W = DIV_W + T_W;
    localparam int P3_W  = PCT_W + 2;
    localparam int BL_W  = C + T_W + 1;
    localparam logic [T_W-1:0] T_ONE = {1'b1, {F{1'b0}}};
    localparam logic [C-1:0]   BIAS  = {1'b1, {(C-1){1'b0}}};

    function automatic logic [C-1:0] f_blend(input logic [C-1:0] p, input logic [C-1:0] q,
                                             input logic [T_W-1:0] s);
        logic [T_W-1:0]  sc;
        logic [BL_W-1:0] acc;
        sc  = T_ONE - s;
        acc = BL_W'(p) * BL_W'(sc) + BL_W'(q) * BL_W'(s) + BL_W'(T_ONE >> 1);
        return acc[F +: C];
    endfunction

    // segment registers
    logic [3*C-1:0]     r_pt [4];
    logic [FRAME_W-1:0] r_first;
    logic [N_W-1:0]     r_n;
    logic               r_clamped;
    logic [PCT_W-1:0]   r_p1, r_c2;
    logic [FRAME_W:0]   span;

    always_comb begin
        span = {1'b0, FRAME_W'(i_frame_last - i_frame_first)} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt[0] <= i_knot_start[3*C-1:0];
            r_pt[1] <= i_handle_out[3*C-1:0];
            r_pt[2] <= i_handle_in[3*C-1:0];
            r_pt[3] <= i_knot_end[3*C-1:0];
            r_first <= i_frame_first;
            r_clamped <= (span > (FRAME_W+1)'(MAX_SAMPLES));
            r_n <= (span > (FRAME_W+1)'(MAX_SAMPLES)) ? N_W'(MAX_SAMPLES) : N_W'(span);
            r_p1 <= (i_ease_out_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : i_ease_out_pct;
            r_c2 <= (i_ease_in_pct > PCT_W'(PCT_FULL)) ? PCT_W'(0)
                  : PCT_W'(PCT_FULL) - i_ease_in_pct;
        end
    end

    // table size and denominator, settle during the first wait
    logic [M_W-1:0]     r_m;
    logic [2*M_W-1:0]   r_m2;
    logic [3*M_W-1:0]   r_m3;
    logic [DEN_W-1:0]   r_den;

    always_ff @(posedge i_clk) begin
        r_m   <= M_W'(r_n * OVERSAMPLE);
        r_m2  <= (2*M_W)'(r_m) * (2*M_W)'(r_m);
        r_m3  <= (3*M_W)'(r_m2) * (3*M_W)'(r_m);
        r_den <= DEN_W'(r_m3) * DEN_W'(PCT_FULL);
    end

    // table entry numerators, one multiply per stage
    logic [A_W-1:0]   r_k;
    logic [M_W-1:0]   k_m, rr, r_kd, r_rd1;
    logic [2*M_W-1:0] r_kr, r_kk;
    logic [3*M_W-1:0] r_krr, r_kkr, r_kkk;
    logic [3*M_W+P3_W-1:0] r_ax, r_bx;
    logic [DEN_W-1:0] r_cx, r_xn, r_yn;
    logic [3*M_W+1:0] r_yk;

    always_comb begin
        k_m = M_W'(r_k);
        rr  = r_m - k_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.load) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kr  <= (2*M_W)'(k_m) * (2*M_W)'(rr);
        r_kk  <= (2*M_W)'(k_m) * (2*M_W)'(k_m);
        r_kd  <= k_m;
        r_rd1 <= rr;
        r_krr <= (3*M_W)'(r_kr) * (3*M_W)'(r_rd1);
        r_kkr <= (3*M_W)'(r_kk) * (3*M_W)'(r_rd1);
        r_kkk <= (3*M_W)'(r_kk) * (3*M_W)'(r_kd);
        r_ax  <= (3*M_W+P3_W)'(r_krr) * (3*M_W+P3_W)'(P3_W'(r_p1) * P3_W'(EASE_TANGENT));
        r_bx  <= (3*M_W+P3_W)'(r_kkr) * (3*M_W+P3_W)'(P3_W'(r_c2) * P3_W'(EASE_TANGENT));
        r_cx  <= DEN_W'(r_kkk) * DEN_W'(PCT_FULL);
        r_yk  <= (3*M_W+2)'(r_kkr) * (3*M_W+2)'(EASE_TANGENT) + (3*M_W+2)'(r_kkk);
        r_xn  <= DEN_W'(r_ax + r_bx + (3*M_W+P3_W)'(r_cx));
        r_yn  <= DEN_W'(r_yk) * DEN_W'(PCT_FULL);
    end

    // sample index, lookup time, search pointer
    logic [N_W-1:0] r_i;
    logic [T_W-1:0] r_t;
    logic [M_W-1:0] r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i  <= '0;
            r_hi <= '0;
        end else begin
            if (i_cmd.load) begin
                r_i <= '0;
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_hi <= '0;
            end else if (i_cmd.scan_inc) begin
                r_hi <= r_hi + 1'b1;
            end
        end
    end

    // shared divider
    logic [NUM_W-1:0] div_num;
    logic [DIV_W-1:0] div_den;
    logic             div_busy, div_done;
    logic [T_W-1:0]   div_q;
    logic [T_W-1:0]   r_rd_x, r_rd_y, r_lo_x, r_lo_y;
    logic [2*T_W-1:0] r_pa, r_pb;
    logic [T_W-1:0]   dx;

    always_comb begin
        dx = r_rd_x - r_lo_x;
        case (i_cmd.div_sel)
            DIV_X: begin
                div_num = (NUM_W'(r_xn) << F) + NUM_W'(r_den >> 1);
                div_den = DIV_W'(r_den);
            end
            DIV_Y: begin
                div_num = (NUM_W'(r_yn) << F) + NUM_W'(r_den >> 1);
                div_den = DIV_W'(r_den);
            end
            DIV_T: begin
                div_num = NUM_W'(r_i) << F;
                div_den = DIV_W'(r_n);
            end
            default: begin
                div_num = NUM_W'(r_pa) + NUM_W'(r_pb) + NUM_W'(dx >> 1);
                div_den = DIV_W'(dx);
            end
        endcase
    end

    ebs_div #(
        .DIV_W (DIV_W),
        .QB    (T_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // ease table
    logic [T_W-1:0] r_mem_x [DEPTH];
    logic [T_W-1:0] r_mem_y [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_x) begin
            r_mem_x[r_k] <= div_q;
        end
        if (i_cmd.wr_y) begin
            r_mem_y[r_k] <= div_q;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[r_hi[A_W-1:0]];
            r_rd_y <= r_mem_y[r_hi[A_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.t_take) begin
            r_t <= div_q;
        end
        if (i_cmd.lo_take) begin
            r_lo_x <= r_rd_x;
            r_lo_y <= r_rd_y;
        end
        r_pa <= (2*T_W)'(r_lo_y) * (2*T_W)'(r_rd_x - r_t);
        r_pb <= (2*T_W)'(r_rd_y) * (2*T_W)'(r_t - r_lo_x);
    end

    // eased time and de Casteljau levels
    logic [T_W-1:0] r_s, s_pick;
    logic [C-1:0]   cb [3][4];
    logic [C-1:0]   r_l1 [3][3];
    logic [C-1:0]   r_l2 [3][2];
    logic [C-1:0]   r_l3 [3];

    always_comb begin
        case (i_cmd.s_sel)
            S_LO:    s_pick = r_lo_y;
            S_HI:    s_pick = r_rd_y;
            default: s_pick = div_q;
        endcase
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
                cb[c][j] = r_pt[j][c*C +: C] ^ BIAS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.s_load) begin
            r_s <= (s_pick > T_ONE) ? T_ONE : s_pick;
        end
        for (int c = 0; c < 3; c++) begin
            r_l1[c][0] <= f_blend(cb[c][0], cb[c][1], r_s);
            r_l1[c][1] <= f_blend(cb[c][1], cb[c][2], r_s);
            r_l1[c][2] <= f_blend(cb[c][2], cb[c][3], r_s);
            r_l2[c][0] <= f_blend(r_l1[c][0], r_l1[c][1], r_s);
            r_l2[c][1] <= f_blend(r_l1[c][1], r_l1[c][2], r_s);
            r_l3[c]    <= f_blend(r_l2[c][0], r_l2[c][1], r_s);
        end
    end

    // output register
    logic                 r_o_valid;
    logic [POINT_W-1:0]   r_o_pos, n_pos;
    logic [FRAME_W-1:0]   r_o_frame;
    logic [EASED_W-1:0]   r_o_et;
    logic                 r_o_clamped, r_o_last;
    logic                 out_free;

    always_comb begin
        n_pos = '0;
        for (int c = 0; c < 3; c++) begin
            n_pos[c*C +: C] = r_l3[c] ^ BIAS;
        end
        out_free = !r_o_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_pos     <= n_pos;
            r_o_frame   <= r_first + FRAME_W'(r_i);
            r_o_et      <= EASED_W'(r_s);
            r_o_clamped <= r_clamped;
            r_o_last    <= (r_i == r_n - 1'b1);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_position    = r_o_pos;
    assign o_frame       = r_o_frame;
    assign o_eased_time  = r_o_et;
    assign o_clamped     = r_o_clamped;
    assign o_last_sample = r_o_last;

    assign o_sts.div_done = div_done;
    assign o_sts.k_last   = (k_m == r_m - 1'b1);
    assign o_sts.i_last   = (r_i == r_n - 1'b1);
    assign o_sts.hi_end   = (r_hi == r_m);
    assign o_sts.x_gt     = (r_rd_x > r_t);
    assign o_sts.degen    = (r_rd_x <= r_lo_x) || (r_t < r_lo_x);
    assign o_sts.out_free = out_free;

`ifndef ASSERT_OFF
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_x || i_cmd.wr_y) |-> (k_m < r_m))
        else $error("table write beyond segment size");
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_hi < r_m))
        else $error("table read beyond segment size");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result beat overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/eased_bezier_segment_sampler_unit.sv
// Eased cubic Bezier segment sampler.
// Input channel (i_valid / o_stall) takes one segment beat: four packed 3D
// points, ease-out and ease-in percentages and the frame range. Output
// channel (o_valid / i_stall) gives one beat per frame, N = last-first+1,
// saturated to MAX_SAMPLES with o_clamped set; o_last_sample marks the end.
// Per segment the block first fills an easing table of M = N*OVERSAMPLE
// entries, each through two passes of a shared restoring divider. Each
// sample then costs one divide for its lookup time, a linear table scan
// from the start of the table, an optional interpolation divide, and the
// de Casteljau blending. The first result appears after the whole table
// fill plus one sample.
// A segment beat is taken only when the previous segment's last result has
// gone into the output register; that register holds a beat while the
// receiver stalls, and the sampler then waits before the next one.
// Reset (synchronous, active low) returns the controller to idle and drops
// any pending result; the table is left as it is and always written first.
`timescale 1ns / 1ps
`default_nettype none
module eased_bezier_segment_sampler_unit
    import ebs_pkg::*;
#(
    parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
    parameter int OVERSAMPLE     = OVERSAMPLE_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [POINT_W-1:0] i_knot_start,
    input  wire logic [POINT_W-1:0] i_handle_out,
    input  wire logic [POINT_W-1:0] i_handle_in,
    input  wire logic [POINT_W-1:0] i_knot_end,
    input  wire logic [PCT_W-1:0]   i_ease_out_pct,
    input  wire logic [PCT_W-1:0]   i_ease_in_pct,
    input  wire logic [FRAME_W-1:0] i_frame_first,
    input  wire logic [FRAME_W-1:0] i_frame_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [POINT_W-1:0]      o_position,
    output logic [FRAME_W-1:0]      o_frame,
    output logic [EASED_W-1:0]      o_eased_time,
    output logic                    o_clamped,
    output logic                    o_last_sample
);
    t_cmd cmd;
    t_sts sts;

    // sequencing: table fill, then per-sample search and blend
    ebs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // arithmetic, table memories and the output register
    ebs_dp #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .OVERSAMPLE     (OVERSAMPLE),
        .COORD_BITS     (COORD_BITS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_knot_start   (i_knot_start),
        .i_handle_out   (i_handle_out),
        .i_handle_in    (i_handle_in),
        .i_knot_end     (i_knot_end),
        .i_ease_out_pct (i_ease_out_pct),
        .i_ease_in_pct  (i_ease_in_pct),
        .i_frame_first  (i_frame_first),
        .i_frame_last   (i_frame_last),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_frame        (o_frame),
        .o_eased_time   (o_eased_time),
        .o_clamped      (o_clamped),
        .o_last_sample  (o_last_sample)
    );

endmodule
`default_nettype wire
